// ----- design/ddq_pkg.sv -----
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types and constants for the dual deque transfer block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddq_pkg;

	localparam int DEPTH    = 64;                  // entries per deque ring
	localparam int AW       = $clog2(DEPTH);       // ring index width
	localparam int CW       = AW + 1;              // element count width
	localparam int DW       = 7;                   // element width
	localparam int INIT_MAX = (DEPTH / 2 < 32) ? DEPTH / 2 : 32;

	// command bit positions
	localparam int CMD_SRC_SIDE = 3;
	localparam int CMD_SRC_BACK = 2;
	localparam int CMD_DST_SIDE = 1;
	localparam int CMD_DST_BACK = 0;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_MOVE = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_WRITE,
		ST_READ
	} state_t;

	// request to the two element memories
	typedef struct packed {
		logic          l_we;
		logic          r_we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] l_wdata;
		logic [DW-1:0] r_wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- design/ddq_ram.sv -----
// ----------------------------------------------------------------------------
// ddq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ddq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/ddq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ddq_ctrl
// Sequencer and ring pointers: decodes requests, drives the element
// memories and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ddq_ctrl
	import ddq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           opcode,
	input  wire logic [3:0]           command,
	input  wire logic                 read_side,
	input  wire logic [5:0]           read_position,
	input  wire logic [5:0]           initial_count,
	input  wire logic [DW-1:0]        l_rdata,
	input  wire logic [DW-1:0]        r_rdata,
	output mem_req_t                  mem_req,
	output logic                      busy,
	output logic                      done,
	output logic                      moved,
	output logic signed [DW-1:0]      moved_value,
	output logic signed [DW-1:0]      read_value,
	output logic                      read_ok,
	output logic [CW-1:0]             left_count,
	output logic [CW-1:0]             right_count
);

	state_t        state_q, state_nx;
	logic [AW-1:0] lf_q, rf_q;
	logic [CW-1:0] ls_q, rs_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] idx_q;
	logic          side_q, dst_q, db_q;
	logic          done_q, moved_q, read_ok_q;
	logic [DW-1:0] moved_value_q, read_value_q;

	logic          acc;
	op_t           op;
	logic          src, sb, dst, db;
	logic [AW-1:0] src_f, rd_f, dst_f, pop_addr, push_addr, rd_addr;
	logic [CW-1:0] src_s, dst_s, rd_s, n_sat;
	logic          mv_go, rd_ok, init_last;
	logic [DW-1:0] rdata_sel, init_val;

	assign acc = start && (state_q == ST_IDLE);
	assign op  = op_t'(opcode);
	assign src = command[CMD_SRC_SIDE];
	assign sb  = command[CMD_SRC_BACK];
	assign dst = command[CMD_DST_SIDE];
	assign db  = command[CMD_DST_BACK];

	assign n_sat = (CW'(initial_count) > CW'(INIT_MAX)) ? CW'(INIT_MAX) : CW'(initial_count);

	// pop side, looked up at accept
	assign src_f    = src ? rf_q : lf_q;
	assign src_s    = src ? rs_q : ls_q;
	assign dst_s    = dst ? rs_q : ls_q;
	assign mv_go    = !((src == dst) && (sb == db)) && (src_s != '0) &&
	                  !((src != dst) && (dst_s >= CW'(DEPTH)));
	assign pop_addr = sb ? src_f + AW'(src_s - CW'(1)) : src_f;

	// read request
	assign rd_f    = read_side ? rf_q : lf_q;
	assign rd_s    = read_side ? rs_q : ls_q;
	assign rd_ok   = CW'(read_position) < rd_s;
	assign rd_addr = rd_f + AW'(read_position);

	// push side, uses pointers already updated by the pop
	assign dst_f     = dst_q ? rf_q : lf_q;
	assign push_addr = db_q ? dst_f + AW'(dst_q ? rs_q : ls_q) : dst_f - AW'(1);

	assign rdata_sel = side_q ? r_rdata : l_rdata;
	assign init_last = (CW'(idx_q) + CW'(1)) == n_q;
	assign init_val  = DW'(idx_q) + DW'(1);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (op)
						OP_INIT: state_nx = (n_sat != '0) ? ST_INIT : ST_IDLE;
						OP_MOVE: state_nx = mv_go ? ST_WRITE : ST_IDLE;
						OP_READ: state_nx = rd_ok ? ST_READ : ST_IDLE;
						OP_NOP:  state_nx = ST_IDLE;
					endcase
				end
			end
			ST_INIT:  state_nx = init_last ? ST_IDLE : ST_INIT;
			ST_WRITE: state_nx = ST_IDLE;
			ST_READ:  state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// memory requests
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (op == OP_MOVE) && mv_go) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = pop_addr;
				end else if (acc && (op == OP_READ) && rd_ok) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_addr;
				end
			end
			ST_INIT: begin
				mem_req.l_we    = 1'b1;
				mem_req.r_we    = 1'b1;
				mem_req.waddr   = idx_q;
				mem_req.l_wdata = init_val;
				mem_req.r_wdata = DW'(0) - init_val;
			end
			ST_WRITE: begin
				mem_req.l_we    = !dst_q;
				mem_req.r_we    = dst_q;
				mem_req.waddr   = push_addr;
				mem_req.l_wdata = rdata_sel;
				mem_req.r_wdata = rdata_sel;
			end
			default: mem_req = '0;
		endcase
	end

	// control state and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lf_q    <= '0;
			rf_q    <= '0;
			ls_q    <= '0;
			rs_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (op)
							OP_INIT: begin
								lf_q   <= '0;
								rf_q   <= '0;
								ls_q   <= n_sat;
								rs_q   <= n_sat;
								done_q <= (n_sat == '0);
							end
							OP_MOVE: begin
								if (mv_go) begin
									if (src) begin
										rs_q <= rs_q - CW'(1);
										if (!sb) rf_q <= rf_q + AW'(1);
									end else begin
										ls_q <= ls_q - CW'(1);
										if (!sb) lf_q <= lf_q + AW'(1);
									end
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_READ: done_q <= !rd_ok;
							OP_NOP:  done_q <= 1'b1;
						endcase
					end
				end
				ST_INIT: done_q <= init_last;
				ST_WRITE: begin
					done_q <= 1'b1;
					if (dst_q) begin
						rs_q <= rs_q + CW'(1);
						if (!db_q) rf_q <= rf_q - AW'(1);
					end else begin
						ls_q <= ls_q + CW'(1);
						if (!db_q) lf_q <= lf_q - AW'(1);
					end
				end
				ST_READ: done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
	end

	// payload: init walk, request fields, result
	always_ff @(posedge clk) begin
		moved_q       <= 1'b0;
		moved_value_q <= '0;
		read_value_q  <= '0;
		read_ok_q     <= 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					n_q    <= n_sat;
					idx_q  <= '0;
					side_q <= (op == OP_READ) ? read_side : src;
					dst_q  <= dst;
					db_q   <= db;
				end
			end
			ST_INIT:  idx_q <= idx_q + AW'(1);
			ST_WRITE: begin
				moved_q       <= 1'b1;
				moved_value_q <= rdata_sel;
			end
			ST_READ: begin
				read_ok_q    <= 1'b1;
				read_value_q <= rdata_sel;
			end
			default: idx_q <= idx_q;
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign moved       = moved_q;
	assign moved_value = moved_value_q;
	assign read_value  = read_value_q;
	assign read_ok     = read_ok_q;
	assign left_count  = ls_q;
	assign right_count = rs_q;

	// elements are only moved, never created beyond init
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(ls_q) + (CW+1)'(rs_q) <= (CW+1)'(DEPTH))
		else $error("deque sizes exceed storage");

	a_write_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> $past(acc))
		else $error("move write without accepted move");

	a_move_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> done_q && moved_q)
		else $error("move write not reported");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> done_q && read_ok_q && !moved_q)
		else $error("read not reported");

endmodule

`default_nettype wire

// ----- design/dual_deque_transfer.sv -----
// ----------------------------------------------------------------------------
// dual_deque_transfer
// Two ring-buffer deques, left and right, with init fill, move and read.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: an item is taken when start is high and busy is low.
//   opcode selects init fill, move (command), read (read_side,
//   read_position) or no operation.
//   Result channel: done pulses for one cycle with moved, moved_value,
//   read_value, read_ok and both counts; the receiver cannot stall it and
//   the next item can be taken in the cycle done is high.
//   Config: cfg_we writes cfg_wdata into initial_count (n, capped at 32).
//   Steps from accept to done:
//     move carried out: memory read, then write-back
//     read in range:    memory read, then result register
//     init:             n entries, one entry of each memory per cycle
//     anything else:    done is registered at accept
//   The element stores are one memory per deque, one write and one
//   registered read port each; that port pair sets the move rate.
//   Reset clears counts, fronts and initial_count; memory contents are not
//   cleared and only entries inside a deque are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_deque_transfer
	import ddq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [5:0]        cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        opcode,
	input  wire logic [3:0]        command,
	input  wire logic              read_side,
	input  wire logic [5:0]        read_position,
	output logic                   done,
	output logic                   moved,
	output logic signed [6:0]      moved_value,
	output logic signed [6:0]      read_value,
	output logic                   read_ok,
	output logic [6:0]             left_count,
	output logic [6:0]             right_count
);

	logic [5:0]    initial_count_q;
	mem_req_t      mem_req;
	logic [DW-1:0] l_rdata, r_rdata;

	// configuration register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_count_q <= '0;
		end else if (cfg_we) begin
			initial_count_q <= cfg_wdata;
		end
	end

	// sequencer and pointers
	ddq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.opcode        (opcode),
		.command       (command),
		.read_side     (read_side),
		.read_position (read_position),
		.initial_count (initial_count_q),
		.l_rdata       (l_rdata),
		.r_rdata       (r_rdata),
		.mem_req       (mem_req),
		.busy          (busy),
		.done          (done),
		.moved         (moved),
		.moved_value   (moved_value),
		.read_value    (read_value),
		.read_ok       (read_ok),
		.left_count    (left_count),
		.right_count   (right_count)
	);

	// left deque storage; both memories share the read address
	ddq_ram #(.DEPTH(DEPTH), .WIDTH(DW)) u_left_ram (
		.clk   (clk),
		.we    (mem_req.l_we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.l_wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (l_rdata)
	);

	// right deque storage
	ddq_ram #(.DEPTH(DEPTH), .WIDTH(DW)) u_right_ram (
		.clk   (clk),
		.we    (mem_req.r_we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.r_wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (r_rdata)
	);

endmodule

`default_nettype wire
